### rtl/core/srg_pkg.sv
// Shared types, operation codes and count reduction for the shift/rotate group unit.
// No dependencies; used by srg_if.sv, srg_step.sv and shift_rotate_group_unit.sv.
package srg_pkg;

    localparam int unsigned DataW  = 16;
    localparam int unsigned CountW = 8;
    localparam int unsigned StepW  = 5;   // up to 17 effective steps

    localparam logic [DataW-1:0] MaskByte = 16'h00FF;
    localparam logic [DataW-1:0] MaskWord = 16'hFFFF;
    localparam logic [DataW-1:0] TopByte  = 16'h0080;
    localparam logic [DataW-1:0] TopWord  = 16'h8000;

    typedef enum logic [2:0] {
        A_ROL = 3'd0,
        A_ROR = 3'd1,
        A_RCL = 3'd2,
        A_RCR = 3'd3,
        A_SHL = 3'd4,
        A_SHR = 3'd5,
        A_SET = 3'd6,
        A_SAR = 3'd7
    } t_action;

    typedef struct packed {
        t_action          act;
        logic             word;
        logic [DataW-1:0] value;
        logic             cf;
    } t_step_in;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             cf;
        logic             of;
        logic             nib;
    } t_step_res;

    // Number of one-bit steps that give the same end state as the full count.
    // Rotates repeat with period 8/16 (9/17 through carry); shifts settle
    // after width+1 steps. Zero for a zero count and for set-all-ones.
    function automatic logic [StepW-1:0] eff_count(input t_action act, input logic word,
                                                   input logic [CountW-1:0] count);
        logic [CountW-1:0] x;
        logic [StepW-1:0]  res;
        x   = count - 8'd1;
        res = '0;
        case (act)
            A_ROL, A_ROR: begin
                res = word ? {1'b0, x[3:0]} + 5'd1 : {2'b00, x[2:0]} + 5'd1;
            end
            A_RCL, A_RCR: begin
                if (word) begin
                    if (x >= 8'd136) x = x - 8'd136;
                    if (x >= 8'd68)  x = x - 8'd68;
                    if (x >= 8'd34)  x = x - 8'd34;
                    if (x >= 8'd17)  x = x - 8'd17;
                end else begin
                    if (x >= 8'd144) x = x - 8'd144;
                    if (x >= 8'd72)  x = x - 8'd72;
                    if (x >= 8'd36)  x = x - 8'd36;
                    if (x >= 8'd18)  x = x - 8'd18;
                    if (x >= 8'd9)   x = x - 8'd9;
                end
                res = x[StepW-1:0] + 5'd1;
            end
            A_SHL, A_SHR, A_SAR: begin
                if (word) res = (count > 8'd17) ? 5'd17 : count[StepW-1:0];
                else      res = (count > 8'd9)  ? 5'd9  : count[StepW-1:0];
            end
            default: res = '0;
        endcase
        if (count == '0) res = '0;
        return res;
    endfunction

endpackage

### rtl/core/srg_if.sv
// Valid/ready request channels of the shift/rotate group unit.
// Depends on srg_pkg for widths.
interface srg_in_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  action;
    logic                        is_word;
    logic [srg_pkg::DataW-1:0]   operand;
    logic [srg_pkg::CountW-1:0]  count;
    logic                        cf_in;
    logic                        of_in;
    logic                        af_in;
    logic                        sf_in;
    logic                        zf_in;
    logic                        pf_in;

    modport source (output valid, action, is_word, operand, count,
                     cf_in, of_in, af_in, sf_in, zf_in, pf_in, input ready);
    modport sink   (input valid, action, is_word, operand, count,
                     cf_in, of_in, af_in, sf_in, zf_in, pf_in, output ready);
endinterface

interface srg_out_if;
    logic                        valid;
    logic                        ready;
    logic [srg_pkg::DataW-1:0]   result;
    logic                        write_back;
    logic                        cf_out;
    logic                        of_out;
    logic                        af_out;
    logic                        sf_out;
    logic                        zf_out;
    logic                        pf_out;

    modport source (output valid, result, write_back, cf_out, of_out, af_out,
                     sf_out, zf_out, pf_out, input ready);
    modport sink   (input valid, result, write_back, cf_out, of_out, af_out,
                     sf_out, zf_out, pf_out, output ready);
endinterface

### rtl/core/srg_step.sv
// Shared one-bit shift/rotate step: one step of any group operation per use.
// Depends on srg_pkg.
module srg_step (
    input  srg_pkg::t_step_in  i_step,
    output srg_pkg::t_step_res o_step
);
    import srg_pkg::*;

    logic [DataW-1:0] mask;
    logic [DataW-1:0] top;
    logic [DataW-1:0] nv;
    logic [DataW-1:0] val;
    logic             msb;
    logic             lsb;
    logic             outb;

    always_comb begin
        mask = i_step.word ? MaskWord : MaskByte;
        top  = i_step.word ? TopWord  : TopByte;
        msb  = |(i_step.value & top);
        lsb  = i_step.value[0];
        case (i_step.act)
            A_ROL: begin
                outb = msb;
                nv   = ((i_step.value << 1) & mask) | {{(DataW-1){1'b0}}, outb};
            end
            A_ROR: begin
                outb = lsb;
                nv   = (i_step.value >> 1) | (outb ? top : '0);
            end
            A_RCL: begin
                outb = msb;
                nv   = ((i_step.value << 1) & mask) | {{(DataW-1){1'b0}}, i_step.cf};
            end
            A_RCR: begin
                outb = lsb;
                nv   = (i_step.value >> 1) | (i_step.cf ? top : '0);
            end
            A_SHL: begin
                outb = msb;
                nv   = (i_step.value << 1) & mask;
            end
            A_SHR: begin
                outb = lsb;
                nv   = i_step.value >> 1;
            end
            default: begin  // SAR; set-all-ones never steps
                outb = lsb;
                nv   = (i_step.value >> 1) | (i_step.value & top);
            end
        endcase
        val          = nv & mask;
        o_step.value = val;
        o_step.cf    = outb;
        o_step.of    = msb != (|(val & top));
        o_step.nib   = i_step.value[3];
    end

endmodule

### rtl/core/shift_rotate_group_unit.sv
// Top level of the shift/rotate group unit: request channels, sequencer, flag logic.
// Depends on srg_pkg, srg_if (srg_in_if, srg_out_if) and srg_step.
//
// Usage:
//   i_req carries one request: action, width, operand, unmasked count and the
//   six incoming flags. o_rsp returns the result, the write-back enable and
//   the six new flags. Both use valid/ready; a request moves on a clock edge
//   where both are high.
//   The unit works on one request at a time. i_req.ready is high only while
//   idle. After the request is taken the count is reduced to the equivalent
//   number of one-bit steps N (0..17): rotates by their period, shifts by
//   capping at width+1. A single shared step unit then runs one bit per
//   cycle until all N steps are done, and the response is shown the cycle after.
//   A zero count or the set-all-ones operation gives N = 0.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
//   o_rsp.valid; any request in flight is lost.
//   When the receiver stalls the response is held stable in its registers
//   and no new request is taken until it is accepted.
module shift_rotate_group_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    srg_in_if.sink           i_req,
    srg_out_if.source        o_rsp
);
    import srg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [StepW-1:0] r_left, n_left;
    t_action          r_act;
    logic             r_word;
    logic             r_wb;
    logic [DataW-1:0] r_val;
    logic             r_cf, r_of, r_af, r_sf, r_zf, r_pf;
    logic             r_nib;

    t_step_in         step_in;
    t_step_res        step_res;

    logic             req_take;
    logic             rsp_take;
    t_action          in_act;
    logic [StepW-1:0] in_steps;
    logic [DataW-1:0] in_mask;
    logic [DataW-1:0] top;
    logic             shift_op;

    assign in_act   = t_action'(i_req.action);
    assign in_mask  = i_req.is_word ? MaskWord : MaskByte;
    assign in_steps = eff_count(in_act, i_req.is_word, i_req.count);
    assign req_take = i_req.valid && i_req.ready;
    assign rsp_take = o_rsp.valid && o_rsp.ready;

    // one shared step unit, fed from the working registers
    assign step_in.act   = r_act;
    assign step_in.word  = r_word;
    assign step_in.value = r_val;
    assign step_in.cf    = r_cf;

    srg_step u_step (
        .i_step (step_in),
        .o_step (step_res)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    n_left  = in_steps;
                    n_state = (in_steps == '0) ? S_OUT : S_RUN;
                end
            end
            S_RUN: begin
                n_left = r_left - 5'd1;
                if (r_left == 5'd1) n_state = S_OUT;
            end
            S_OUT: begin
                if (rsp_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_act  <= in_act;
            r_word <= i_req.is_word;
            r_wb   <= i_req.count != '0;
            r_af   <= i_req.af_in;
            r_sf   <= i_req.sf_in;
            r_zf   <= i_req.zf_in;
            r_pf   <= i_req.pf_in;
            r_nib  <= 1'b0;
            if (in_act == A_SET && i_req.count != '0) begin
                r_val <= in_mask;
                r_cf  <= 1'b0;
                r_of  <= 1'b0;
            end else begin
                r_val <= i_req.operand & in_mask;
                r_cf  <= i_req.cf_in;
                r_of  <= i_req.of_in;
            end
        end else if (r_state == S_RUN) begin
            r_val <= step_res.value;
            r_cf  <= step_res.cf;
            r_of  <= step_res.of;
            r_nib <= step_res.nib;
        end
    end

    // nonzero shifts and set-all-ones rebuild SF/ZF/PF/AF; rotates pass them through
    assign top      = r_word ? TopWord : TopByte;
    assign shift_op = r_wb && (r_act == A_SHL || r_act == A_SHR ||
                               r_act == A_SET || r_act == A_SAR);

    assign i_req.ready      = r_state == S_IDLE;
    assign o_rsp.valid      = r_state == S_OUT;
    assign o_rsp.result     = r_val;
    assign o_rsp.write_back = r_wb;
    assign o_rsp.cf_out     = r_cf;
    assign o_rsp.of_out     = r_of;
    assign o_rsp.af_out     = shift_op ? (r_act == A_SHL && r_nib) : r_af;
    assign o_rsp.sf_out     = shift_op ? |(r_val & top) : r_sf;
    assign o_rsp.zf_out     = shift_op ? (r_val == '0) : r_zf;
    assign o_rsp.pf_out     = shift_op ? ~(^r_val[7:0]) : r_pf;

    // checks
    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> (r_left != '0 && r_left <= 5'd17))
        else $error("step counter out of range while running");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> !i_req.ready)
        else $error("request taken while previous one still in work");

    a_byte_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !r_word |-> o_rsp.result[15:8] == 8'h00)
        else $error("byte result has nonzero upper byte");

    a_set_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && r_wb && r_act == A_SET |->
            (o_rsp.result == (r_word ? MaskWord : MaskByte) && !o_rsp.cf_out))
        else $error("set-all-ones result wrong");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take && i_req.count == '0 |=> o_rsp.valid && !o_rsp.write_back)
        else $error("zero count must answer at once without write-back");

endmodule

### tb/shift_rotate_group_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for shift_rotate_group_unit: directed and random requests.
// Depends on srg_pkg, srg_if.sv (srg_in_if, srg_out_if) and the unit's RTL.
module shift_rotate_group_unit_tb;
    import srg_pkg::*;

    // Cycles with no accepted request or response before the run is called hung.
    // It lies well above the slowest legal interval and the long response hold below.
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned DRAIN_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 25;   // longer than the slowest request period
    localparam int unsigned RAND_ITEMS  = 1000;

    typedef struct {
        t_action          action;
        logic             is_word;
        logic [DataW-1:0] operand;
        logic [CountW-1:0] count;
        logic [5:0]       flags;    // {cf, of, af, sf, zf, pf}
    } srg_request_t;

    typedef struct {
        logic [DataW-1:0] result;
        logic             write_back;
        logic             cf, of, af, sf, zf, pf;
    } srg_response_t;

    // Predicts every response from the requests taken and holds them in order.
    class srg_flag_scoreboard;
        srg_response_t pending_results[$];
        int unsigned   error_count;

        function new();
            error_count = 0;
        endfunction

        // One-bit steps exactly as the architecture defines them, count unmasked.
        function srg_response_t compute_shift_result(srg_request_t r);
            srg_response_t    p;
            logic [DataW-1:0] mask, top, value, nv;
            logic             msb, lsb, outb, nib;
            int unsigned      i;
            mask  = r.is_word ? MaskWord : MaskByte;
            top   = r.is_word ? TopWord : TopByte;
            value = r.operand & mask;
            {p.cf, p.of, p.af, p.sf, p.zf, p.pf} = r.flags;
            p.write_back = 1'b0;
            nib = 1'b0;
            if (r.count != '0) begin
                p.write_back = 1'b1;
                if (r.action == A_SET) begin
                    value = mask;
                    p.cf  = 1'b0;
                    p.of  = 1'b0;
                end else begin
                    for (i = 0; i < r.count; i++) begin
                        msb = |(value & top);
                        lsb = value[0];
                        nib = value[3];
                        case (r.action)
                            A_ROL: begin
                                outb = msb;
                                nv   = ((value << 1) & mask) | {{(DataW-1){1'b0}}, outb};
                            end
                            A_ROR: begin
                                outb = lsb;
                                nv   = (value >> 1) | (outb ? top : '0);
                            end
                            A_RCL: begin
                                outb = msb;
                                nv   = ((value << 1) & mask) | {{(DataW-1){1'b0}}, p.cf};
                            end
                            A_RCR: begin
                                outb = lsb;
                                nv   = (value >> 1) | (p.cf ? top : '0);
                            end
                            A_SHL: begin
                                outb = msb;
                                nv   = (value << 1) & mask;
                            end
                            A_SHR: begin
                                outb = lsb;
                                nv   = value >> 1;
                            end
                            default: begin
                                outb = lsb;
                                nv   = (value >> 1) | (value & top);
                            end
                        endcase
                        value = nv & mask;
                        p.cf  = outb;
                        p.of  = msb ^ (|(value & top));
                    end
                end
                if (r.action inside {A_SHL, A_SHR, A_SET, A_SAR}) begin
                    p.sf = |(value & top);
                    p.zf = (value == '0);
                    p.pf = ~^value[7:0];
                    p.af = (r.action == A_SHL) ? nib : 1'b0;
                end
            end
            p.result = value;
            return p;
        endfunction

        function void note_request(srg_request_t r);
            pending_results.push_back(compute_shift_result(r));
        endfunction

        function void compare_field(string name, logic [DataW-1:0] exp, logic [DataW-1:0] got);
            if (exp !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
                error_count++;
            end
        endfunction

        function void check_response(srg_response_t got);
            srg_response_t exp;
            if (pending_results.size() == 0) begin
                $error("response with no request outstanding: result 0x%0h", got.result);
                error_count++;
                return;
            end
            exp = pending_results.pop_front();
            compare_field("result", exp.result, got.result);
            compare_field("write_back", DataW'(exp.write_back), DataW'(got.write_back));
            compare_field("cf_out", DataW'(exp.cf), DataW'(got.cf));
            compare_field("of_out", DataW'(exp.of), DataW'(got.of));
            compare_field("af_out", DataW'(exp.af), DataW'(got.af));
            compare_field("sf_out", DataW'(exp.sf), DataW'(got.sf));
            compare_field("zf_out", DataW'(exp.zf), DataW'(got.zf));
            compare_field("pf_out", DataW'(exp.pf), DataW'(got.pf));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    srg_in_if  req_if ();
    srg_out_if rsp_if ();

    shift_rotate_group_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    srg_flag_scoreboard sb = new();

    // Knobs shared between the request driver (main process) and the response side.
    int unsigned rsp_hold_cycles = 0;   // long receiver hold, counted down by the receiver
    bit          no_idle         = 1'b0; // both sides run flat out while set
    int unsigned rsp_gap_left    = 0;
    int unsigned idle_cycles     = 0;

    always #4 i_clk = ~i_clk;

    // Mostly back-to-back, sometimes a few cycles, now and then a long gap.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic srg_request_t make_request(t_action act, logic word,
                                                  logic [DataW-1:0] operand,
                                                  logic [CountW-1:0] count,
                                                  logic [5:0] flags);
        srg_request_t r;
        r.action  = act;
        r.is_word = word;
        r.operand = operand;
        r.count   = count;
        r.flags   = flags;
        return r;
    endfunction

    // Random request: counts mostly within one period so each step position is hit,
    // plus zero, one and the full 8-bit range; operands mix corners and noise.
    function automatic srg_request_t random_request();
        srg_request_t r;
        int unsigned  pick;
        r.action  = t_action'($urandom_range(0, 7));
        r.is_word = 1'($urandom_range(0, 1));
        r.flags   = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if      (pick < 10) r.count = '0;
        else if (pick < 22) r.count = 8'd1;
        else if (pick < 75) r.count = CountW'($urandom_range(1, 18));
        else                r.count = CountW'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       r.operand = '0;
            1:       r.operand = 16'hFFFF;
            2:       r.operand = 16'h8000;
            3:       r.operand = 16'h0080;
            4:       r.operand = 16'h0001;
            default: r.operand = DataW'($urandom_range(0, 16'hFFFF));
        endcase
        return r;
    endfunction

    // Offer one request at the current falling edge, after an optional gap, and
    // return at the falling edge after it is taken. All fields but the flags are scrambled during a gap.
    task automatic drive_request(input srg_request_t r, input int unsigned gap);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            {req_if.action, req_if.is_word, req_if.operand, req_if.count} <=
                (3 + 1 + DataW + CountW)'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.action  <= r.action;
        req_if.is_word <= r.is_word;
        req_if.operand <= r.operand;
        req_if.count   <= r.count;
        {req_if.cf_in, req_if.of_in, req_if.af_in,
         req_if.sf_in, req_if.zf_in, req_if.pf_in} <= r.flags;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained(input int unsigned limit);
        int unsigned n;
        n = 0;
        while (sb.pending_results.size() != 0 && n < limit) begin
            @(negedge i_clk);
            n++;
        end
    endtask

    // Receiver: random ready, a long hold on request, or always ready.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles != 0) begin
                rsp_if.ready <= 1'b0;
                rsp_hold_cycles--;
            end else if (no_idle) begin
                rsp_if.ready <= 1'b1;
            end else if (rsp_gap_left != 0) begin
                rsp_if.ready <= 1'b0;
                rsp_gap_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) rsp_gap_left = pick_gap();
            end
        end
    end

    // Monitor: sample both handshakes at the rising edge; watchdog on no progress.
    always @(posedge i_clk) begin
        srg_request_t  r;
        srg_response_t p;
        if (i_rst_n) begin
            idle_cycles++;
            if (req_if.valid && req_if.ready) begin
                r.action  = t_action'(req_if.action);
                r.is_word = req_if.is_word;
                r.operand = req_if.operand;
                r.count   = req_if.count;
                r.flags   = {req_if.cf_in, req_if.of_in, req_if.af_in,
                             req_if.sf_in, req_if.zf_in, req_if.pf_in};
                sb.note_request(r);
                idle_cycles = 0;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                p.result     = rsp_if.result;
                p.write_back = rsp_if.write_back;
                p.cf         = rsp_if.cf_out;
                p.of         = rsp_if.of_out;
                p.af         = rsp_if.af_out;
                p.sf         = rsp_if.sf_out;
                p.zf         = rsp_if.zf_out;
                p.pf         = rsp_if.pf_out;
                sb.check_response(p);
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("shift_rotate_group_unit_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        srg_request_t directed_q[$];
        int unsigned  n;
        int unsigned  gap;

        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid   = 1'b0;
        req_if.action  = '0;
        req_if.is_word = 1'b0;
        req_if.operand = '0;
        req_if.count   = '0;
        {req_if.cf_in, req_if.of_in, req_if.af_in,
         req_if.sf_in, req_if.zf_in, req_if.pf_in} = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every operation, both widths, zero count pass-through,
        // full carry-rotate periods, settled shifts, AF from bit 3, ignored
        // upper byte, and set-all-ones with any count.
        directed_q.push_back(make_request(A_ROL, 1'b0, 16'h0081, 8'd1,   6'b000000));
        directed_q.push_back(make_request(A_ROR, 1'b1, 16'h0001, 8'd1,   6'b111111));
        directed_q.push_back(make_request(A_RCL, 1'b0, 16'h00A5, 8'd9,   6'b100000));
        directed_q.push_back(make_request(A_RCR, 1'b1, 16'h5A5A, 8'd17,  6'b100000));
        directed_q.push_back(make_request(A_SHL, 1'b0, 16'h0008, 8'd1,   6'b000000));
        directed_q.push_back(make_request(A_SHR, 1'b1, 16'hFFFF, 8'd16,  6'b111111));
        directed_q.push_back(make_request(A_SET, 1'b0, 16'h1234, 8'd1,   6'b111000));
        directed_q.push_back(make_request(A_SAR, 1'b1, 16'h8000, 8'd255, 6'b000000));
        directed_q.push_back(make_request(A_SHL, 1'b1, 16'hFFFF, 8'd255, 6'b010101));
        directed_q.push_back(make_request(A_ROL, 1'b0, 16'hFFFF, 8'd0,   6'b111111));
        directed_q.push_back(make_request(A_SHL, 1'b1, 16'hC3C3, 8'd0,   6'b101010));
        directed_q.push_back(make_request(A_SET, 1'b1, 16'h0000, 8'd200, 6'b111111));
        directed_q.push_back(make_request(A_SET, 1'b1, 16'hBEEF, 8'd0,   6'b010101));
        directed_q.push_back(make_request(A_RCL, 1'b1, 16'h8001, 8'd255, 6'b100000));
        directed_q.push_back(make_request(A_RCR, 1'b0, 16'h0081, 8'd255, 6'b000000));
        directed_q.push_back(make_request(A_ROL, 1'b1, 16'h8000, 8'd16,  6'b000000));
        directed_q.push_back(make_request(A_ROR, 1'b0, 16'h00FF, 8'd255, 6'b000000));
        directed_q.push_back(make_request(A_SHR, 1'b0, 16'h0080, 8'd8,   6'b011111));
        directed_q.push_back(make_request(A_SAR, 1'b0, 16'h007F, 8'd9,   6'b111111));
        directed_q.push_back(make_request(A_SHL, 1'b0, 16'h0000, 8'd10,  6'b000000));
        directed_q.push_back(make_request(A_ROL, 1'b0, 16'hAB55, 8'd3,   6'b000000));
        directed_q.push_back(make_request(A_SAR, 1'b0, 16'hFF80, 8'd1,   6'b000000));
        directed_q.push_back(make_request(A_SHL, 1'b1, 16'h4008, 8'd1,   6'b000000));
        foreach (directed_q[i]) drive_request(directed_q[i], pick_gap());

        // Random requests in phases:
        //   300..319  receiver starts a long hold-off while requests keep coming,
        //             so the unit fills and stalls its input
        //   500       sender pauses until every response is back
        //   700..799  both sides flat out, no idling
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == 300) rsp_hold_cycles = 400;
            if (n == 500) wait_drained(DRAIN_LIMIT);
            if (n == 700) no_idle = 1'b1;
            if (n == 800) no_idle = 1'b0;
            gap = (no_idle || (n >= 300 && n < 320)) ? 0 : pick_gap();
            drive_request(random_request(), gap);
        end
        req_if.valid <= 1'b0;

        wait_drained(DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.pending_results.size() != 0) begin
            $error("%0d responses never arrived", sb.pending_results.size());
        end
        if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
            $display("shift_rotate_group_unit_tb: PASS");
        end else begin
            $display("shift_rotate_group_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
